@@ hw/rtl/bsop_pkg.sv @@
// Shared types and constants for the buffer slot ownership pool.
// Depends on nothing; every other file of the block depends on it.
package bsop_pkg;

    // Field widths of the request and response channels.
    localparam int KIND_W       = 3;
    localparam int SLOT_IDX_W   = 6;
    localparam int FRAMES_W     = 8;
    localparam int STATUS_W     = 3;
    localparam int SLOT_STATE_W = 3;

    // Default pool size; the top level may override it (1 to 64).
    localparam int NUM_SLOTS_DEF = 8;

    // Request kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_RESERVE  = 3'd0,
        KIND_SUBMIT   = 3'd1,
        KIND_COLLECT  = 3'd2,
        KIND_RELEASE  = 3'd3,
        KIND_FAIL     = 3'd4,
        KIND_QUERY    = 3'd5
    } t_kind;

    // Ownership state of one slot.
    typedef enum logic [SLOT_STATE_W-1:0] {
        ST_FREE       = 3'd0,
        ST_RESERVED   = 3'd1,
        ST_SUBMITTED  = 3'd2,
        ST_COMPLETING = 3'd3,
        ST_FAILED     = 3'd4
    } t_slot_state;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        RC_OK        = 3'd0,
        RC_NO_FREE   = 3'd1,
        RC_RANGE     = 3'd2,
        RC_STATE     = 3'd3,
        RC_EMPTY     = 3'd4,
        RC_NOT_OWNED = 3'd5
    } t_status;

    // One request as held in the input register.
    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [FRAMES_W-1:0]   batch_frames;
    } t_req;

    // One response as held in the result register.
    typedef struct packed {
        t_status               status;
        logic [SLOT_IDX_W-1:0] granted_slot;
        logic [SLOT_STATE_W-1:0] slot_state;
    } t_rsp;

endpackage

@@ hw/rtl/bsop_if.sv @@
// Valid/ready channel interfaces for requests and responses of the pool.
// Depends on bsop_pkg for the field widths.
interface bsop_req_if;
    logic                             valid;
    logic                             ready;
    logic [bsop_pkg::KIND_W-1:0]      kind;
    logic [bsop_pkg::SLOT_IDX_W-1:0]  slot_index;
    logic [bsop_pkg::FRAMES_W-1:0]    batch_frames;

    modport source (output valid, output kind, output slot_index, output batch_frames,
                    input ready);
    modport sink   (input valid, input kind, input slot_index, input batch_frames,
                    output ready);
endinterface

interface bsop_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [bsop_pkg::STATUS_W-1:0]      status;
    logic [bsop_pkg::SLOT_IDX_W-1:0]    granted_slot;
    logic [bsop_pkg::SLOT_STATE_W-1:0]  slot_state;

    modport source (output valid, output status, output granted_slot, output slot_state,
                    input ready);
    modport sink   (input valid, input status, input granted_slot, input slot_state,
                    output ready);
endinterface

@@ hw/rtl/buffer_slot_ownership_pool.sv @@
// Buffer slot ownership pool: top level with request decode, slot state and result register.
// Depends on bsop_pkg, bsop_if.sv and bsop_first_free.
//
// Each request is taken into an input register, decoded against the slot state table and
// answered through a result register, so a new request can be accepted every cycle while
// the output is not stalled; each response is loaded into the result register as its request
// leaves the input register. The decode (a lowest-free-slot search and one table update) is
// combinational. The state table is updated at the same edge that loads the response, so the
// next request always sees the effect of the previous one. A stalled response holds the input
// register, which in turn drops ready. After reset all slots are free; a failed slot stays
// failed for good. Reserve grants the lowest free slot or answers "no free slot".
module buffer_slot_ownership_pool #(
    parameter int NUM_SLOTS = bsop_pkg::NUM_SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bsop_req_if.sink      i_req,
    bsop_rsp_if.source    o_rsp
);
    import bsop_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Input and result registers.
    logic        r_in_valid;
    t_req        r_req;
    logic        r_out_valid;
    t_rsp        r_rsp;
    t_slot_state r_slot_state [NUM_SLOTS];

    logic                  w_adv;
    logic [NUM_SLOTS-1:0]  w_free;
    logic                  w_found;
    logic [IDX_W-1:0]      w_grant;
    logic                  w_in_range;
    logic [IDX_W-1:0]      w_idx;
    t_slot_state           w_cur;
    logic                  w_upd;
    logic [IDX_W-1:0]      w_upd_idx;
    t_slot_state           w_upd_val;
    t_rsp                  w_rsp;

    // The held request moves on when the result register is empty or being drained.
    assign w_adv       = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_adv;

    // Free flags feed the lowest-free-slot finder.
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            w_free[i] = (r_slot_state[i] == ST_FREE);
        end
    end

    bsop_first_free #(
        .NUM_SLOTS (NUM_SLOTS),
        .IDX_W     (IDX_W)
    ) u_first_free (
        .i_free  (w_free),
        .o_found (w_found),
        .o_slot  (w_grant)
    );

    // Range check and read of the named slot.
    assign w_in_range = ({1'b0, r_req.slot_index} < (SLOT_IDX_W+1)'(NUM_SLOTS));
    assign w_idx      = r_req.slot_index[IDX_W-1:0];
    assign w_cur      = w_in_range ? r_slot_state[w_idx] : ST_FREE;

    // Request decode: response fields and the single state update.
    always_comb begin
        w_rsp.status       = RC_OK;
        w_rsp.granted_slot = '0;
        w_rsp.slot_state   = '0;
        w_upd              = 1'b0;
        w_upd_idx          = w_idx;
        w_upd_val          = ST_FREE;
        unique case (r_req.kind)
            KIND_RESERVE: begin
                if (w_found) begin
                    w_rsp.granted_slot = SLOT_IDX_W'(w_grant);
                    w_upd              = 1'b1;
                    w_upd_idx          = w_grant;
                    w_upd_val          = ST_RESERVED;
                end else begin
                    w_rsp.status = RC_NO_FREE;
                end
            end
            KIND_SUBMIT: begin
                if (r_req.batch_frames == '0) begin
                    w_rsp.status = RC_EMPTY;
                end else if (!w_in_range) begin
                    w_rsp.status = RC_RANGE;
                end else if (w_cur != ST_RESERVED) begin
                    w_rsp.status = RC_STATE;
                end else begin
                    w_upd     = 1'b1;
                    w_upd_val = ST_SUBMITTED;
                end
            end
            KIND_COLLECT: begin
                if (!w_in_range) begin
                    w_rsp.status = RC_RANGE;
                end else if (w_cur != ST_SUBMITTED) begin
                    w_rsp.status = RC_STATE;
                end else begin
                    w_upd     = 1'b1;
                    w_upd_val = ST_COMPLETING;
                end
            end
            KIND_RELEASE: begin
                if (!w_in_range) begin
                    w_rsp.status = RC_RANGE;
                end else if (w_cur != ST_COMPLETING) begin
                    w_rsp.status = RC_STATE;
                end else begin
                    w_upd     = 1'b1;
                    w_upd_val = ST_FREE;
                end
            end
            KIND_FAIL: begin
                if (!w_in_range || w_cur == ST_FREE) begin
                    w_rsp.status = RC_NOT_OWNED;
                end else begin
                    w_upd     = 1'b1;
                    w_upd_val = ST_FAILED;
                end
            end
            KIND_QUERY: begin
                if (!w_in_range) begin
                    w_rsp.status = RC_RANGE;
                end else begin
                    w_rsp.slot_state = w_cur;
                end
            end
            default: begin
                // Unused kind codes are answered with OK and change nothing.
            end
        endcase
    end

    // Input register: take a transfer whenever ready is high.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
        if (i_req.ready) begin
            r_req.kind         <= i_req.kind;
            r_req.slot_index   <= i_req.slot_index;
            r_req.batch_frames <= i_req.batch_frames;
        end
    end

    // Slot state table, written at most once per processed request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_slot_state[i] <= ST_FREE;
            end
        end else if (w_adv && w_upd) begin
            r_slot_state[w_upd_idx] <= w_upd_val;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_rsp.status;
    assign o_rsp.granted_slot = r_rsp.granted_slot;
    assign o_rsp.slot_state   = r_rsp.slot_state;

`ifndef NO_ASSERTIONS
    // A failed slot never leaves the failed state.
    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_fail_sticky
        a_fail_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_slot_state[g] == ST_FAILED |=> r_slot_state[g] == ST_FAILED)
            else $error("failed slot %0d left the failed state", g);
    end

    // A held request is not dropped while the result side stalls.
    a_hold_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_req))
        else $error("pending request lost during output stall");

    // A granted slot is reported only with OK status, and then it is reserved.
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_req.kind == KIND_RESERVE && w_found
        |=> r_rsp.status == RC_OK && r_slot_state[$past(w_grant)] == ST_RESERVED)
        else $error("reserve grant not reflected in slot state");
`endif

endmodule

@@ hw/rtl/bsop_first_free.sv @@
// Lowest-set-bit finder over the per-slot free flags.
// Depends on bsop_pkg for the default pool size.
module bsop_first_free #(
    parameter int NUM_SLOTS = bsop_pkg::NUM_SLOTS_DEF,
    parameter int IDX_W     = 3
) (
    input  logic [NUM_SLOTS-1:0] i_free,
    output logic                 o_found,
    output logic [IDX_W-1:0]     o_slot
);

    logic [NUM_SLOTS-1:0] w_lowest;

    // Isolate the lowest free flag; the result is one-hot or zero.
    assign w_lowest = i_free & (~i_free + {{(NUM_SLOTS-1){1'b0}}, 1'b1});
    assign o_found  = |i_free;

    // Encode the one-hot vector: each index ORs in independently.
    always_comb begin
        o_slot = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (w_lowest[i]) begin
                o_slot = o_slot | IDX_W'(i);
            end
        end
    end

endmodule
